// File: hdl/lbp_pkg.sv
// Package for the two-level local-history branch predictor.
// Holds defaults, counter codes, command codes, the sequencer state type and the counter training function.
// No dependencies.
package lbp_pkg;

   localparam int ENTRY_COUNT_DEFAULT  = 4096;
   localparam int HISTORY_BITS_DEFAULT = 2;

   // Table row: local history in the low bits, then one 2-bit counter per pattern
   localparam int ROW_BITS_DEFAULT =
      HISTORY_BITS_DEFAULT + (2 << HISTORY_BITS_DEFAULT);
   localparam int ADDR_BITS_DEFAULT = $clog2(ENTRY_COUNT_DEFAULT);

   typedef logic [1:0] counter_type;

   // Counter codes: low half predicts taken
   localparam counter_type CTR_STRONG_TAKEN = 2'd0;
   localparam counter_type CTR_RESET        = 2'd1;
   localparam counter_type CTR_TAKEN_LIMIT  = 2'd2;
   localparam counter_type CTR_MAX          = 2'd3;

   localparam logic CMD_PREDICT = 1'b0;
   localparam logic CMD_UPDATE  = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Train a counter toward the resolved outcome, saturating at both ends
   function automatic counter_type counter_next(input counter_type ctr, input logic taken);
      counter_type result;
      if (taken) begin
         result = (ctr == CTR_STRONG_TAKEN) ? CTR_STRONG_TAKEN : ctr - 2'd1;
      end else begin
         result = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
      end
      return result;
   endfunction

endpackage

// File: hdl/lbp_table.sv
// Predictor table: one row per entry, one write port and one registered read port.
// Depends on lbp_pkg for parameter defaults.
module lbp_table #(
   parameter int DEPTH     = lbp_pkg::ENTRY_COUNT_DEFAULT,
   parameter int ADDR_BITS = lbp_pkg::ADDR_BITS_DEFAULT,
   parameter int ROW_BITS  = lbp_pkg::ROW_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [ROW_BITS-1:0]  wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [ROW_BITS-1:0]  rd_data
);

   logic [ROW_BITS-1:0] mem [DEPTH];
   logic [ROW_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/two_level_local_branch_predictor.sv
// Two-level local-history branch predictor, top level.
// Results: the table row is read at the accepting edge; strobe and prediction are registered
// from ST_EXEC. A new request is taken only in ST_IDLE: busy stays high through ST_EXEC,
// where the table read-modify-write completes (write back on update only). Results cannot be stalled.
// Reset: a clearing pass writes every table row, with busy high throughout.
// Depends on lbp_pkg and lbp_table. ENTRY_COUNT must be a power of two; the block itself does not enforce it.
module two_level_local_branch_predictor #(
   parameter int ENTRY_COUNT  = lbp_pkg::ENTRY_COUNT_DEFAULT,
   parameter int HISTORY_BITS = lbp_pkg::HISTORY_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [11:0] req_entry_index,
   input  logic        req_outcome_taken,
   output logic        rsp_strobe,
   output logic        rsp_predict_taken
);

   localparam int ADDR_BITS     = $clog2(ENTRY_COUNT);
   localparam int PATTERN_COUNT = 1 << HISTORY_BITS;
   localparam int ROW_BITS      = HISTORY_BITS + 2 * PATTERN_COUNT;

   lbp_pkg::state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic                 cmd_ff, cmd_in;
   logic [ADDR_BITS-1:0] idx_ff, idx_in;
   logic                 taken_ff, taken_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_pred_ff, rsp_pred_in;

   logic                    accept;
   logic                    wr_en;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [ROW_BITS-1:0]     wr_data;
   logic [ROW_BITS-1:0]     rd_row;
   logic [ROW_BITS-1:0]     reset_row;
   logic [ROW_BITS-1:0]     upd_row;
   logic [HISTORY_BITS-1:0] hist;
   lbp_pkg::counter_type    ctr;
   logic                    pred;

   assign busy   = (state_ff != lbp_pkg::ST_IDLE);
   assign accept = start && !busy;

   lbp_table #(
      .DEPTH     (ENTRY_COUNT),
      .ADDR_BITS (ADDR_BITS),
      .ROW_BITS  (ROW_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (ADDR_BITS'(req_entry_index)),
      .rd_data (rd_row)
   );

   // Row as left by reset: zero history, every counter weakly taken
   always_comb begin
      reset_row = '0;
      for (int p = 0; p < PATTERN_COUNT; p++) begin
         reset_row[HISTORY_BITS + 2 * p +: 2] = lbp_pkg::CTR_RESET;
      end
   end

   // Select the counter by the entry's history, train it, shift the outcome in
   always_comb begin
      hist    = rd_row[HISTORY_BITS-1:0];
      ctr     = rd_row[HISTORY_BITS + 2 * hist +: 2];
      pred    = (ctr < lbp_pkg::CTR_TAKEN_LIMIT);
      upd_row = rd_row;
      upd_row[HISTORY_BITS + 2 * hist +: 2] = lbp_pkg::counter_next(ctr, taken_ff);
      upd_row[HISTORY_BITS-1:0] = HISTORY_BITS'({hist, taken_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lbp_pkg::ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      taken_ff    <= taken_in;
      rsp_pred_ff <= rsp_pred_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      taken_in      = taken_ff;
      rsp_strobe_in = 1'b0;
      rsp_pred_in   = rsp_pred_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = upd_row;
      unique case (state_ff)
         lbp_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = reset_row;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_BITS'(ENTRY_COUNT - 1)) begin
               state_in = lbp_pkg::ST_IDLE;
            end
         end
         lbp_pkg::ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               idx_in   = ADDR_BITS'(req_entry_index);
               taken_in = req_outcome_taken;
               state_in = lbp_pkg::ST_EXEC;
            end
         end
         lbp_pkg::ST_EXEC: begin
            // report the prediction as read, write back only on update
            wr_en         = (cmd_ff == lbp_pkg::CMD_UPDATE);
            rsp_strobe_in = 1'b1;
            rsp_pred_in   = pred;
            state_in      = lbp_pkg::ST_IDLE;
         end
         default: begin
            state_in = lbp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_predict_taken = rsp_pred_ff;

endmodule
